// File: src/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants for the min tracking stack: operation and
// status codes, data width and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int DATA_W = 32;

  // operation codes
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // minimum reported for an empty stack
  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

  // controller to datapath
  typedef struct packed {
    logic exec;    // an item is accepted this cycle
    logic finish;  // memory read data is ready, complete a pop
  } mts_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_fetch;  // current item is a pop that leaves entries behind
  } mts_sts_t;

endpackage

// File: src/mts_ctrl.sv
// ----------------------------------------------------------------------------
// mts_ctrl
// Sequencer for the min tracking stack: handshakes on both channels, holds
// the result-valid flag and adds a wait state for pops that read memory.
// ----------------------------------------------------------------------------
module mts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mts_pkg::mts_sts_t sts,
  output mts_pkg::mts_cmd_t cmd
);
  import mts_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_FETCH
  } state_t;

  state_t state;
  logic   accept;

  // take an item when idle and the result slot is free or draining
  assign in_ready   = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept     = in_valid && in_ready;
  assign cmd.exec   = accept;
  assign cmd.finish = (state == S_FETCH);

  // hold state and result-valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && sts.need_fetch) begin
            state     <= S_FETCH;
            out_valid <= 1'b0;
          end else if (accept) begin
            out_valid <= 1'b1;
          end else if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
        end
        S_FETCH: begin
          state     <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: begin
          state     <= S_IDLE;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

  // a pending pop never overlaps a waiting result
  assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH) |-> !out_valid)
    else $error("result valid while pop fetch pending");

  // a deep pop passes through the fetch state, then presents its result
  assert property (@(posedge clk) disable iff (rst)
    (accept && sts.need_fetch) |=> (state == S_FETCH) ##1 (out_valid && state == S_IDLE))
    else $error("deep pop did not complete in two cycles");

  // any other accepted item shows its result on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (accept && !sts.need_fetch) |=> out_valid)
    else $error("result missing after accepted item");

endmodule

// File: src/mts_dp.sv
// ----------------------------------------------------------------------------
// mts_dp
// Datapath for the min tracking stack: entry memory with a running minimum
// per slot, fill count, cached top entry and the result registers.
// ----------------------------------------------------------------------------
module mts_dp #(
  parameter int DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [1:0]                        opcode,
  input  logic signed [mts_pkg::DATA_W-1:0] push_value,
  input  mts_pkg::mts_cmd_t                 cmd,
  output mts_pkg::mts_sts_t                 sts,
  output logic signed [mts_pkg::DATA_W-1:0] top_value,
  output logic signed [mts_pkg::DATA_W-1:0] min_value,
  output logic                              is_empty,
  output logic [1:0]                        status
);
  import mts_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // each slot holds {value, minimum of this slot and all below}
  logic [2*DATA_W-1:0] mem [DEPTH];
  logic [2*DATA_W-1:0] rd_data;

  logic [CW-1:0]              fill_count;
  logic signed [DATA_W-1:0]   top_val;
  logic signed [DATA_W-1:0]   top_min;

  logic                       is_push, is_pop, full, empty;
  logic signed [DATA_W-1:0]   push_min;
  logic [CW-1:0]              below_idx;
  logic                       mem_we;

  assign is_push   = (opcode == OP_PUSH);
  assign is_pop    = (opcode == OP_POP);
  assign full      = (fill_count == CW'(DEPTH));
  assign empty     = (fill_count == '0);
  assign below_idx = fill_count - CW'(2);

  // pop that leaves a new top in memory needs the fetch state to read it
  assign sts.need_fetch = is_pop && (fill_count > CW'(1));

  // running minimum of the new entry and everything below
  assign push_min = (!empty && (top_min < push_value)) ? top_min : push_value;

  assign mem_we = cmd.exec && is_push && !full;

  // write pushed slot, read the slot under the top every cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill_count[AW-1:0]] <= {push_value, push_min};
    end
    rd_data <= mem[below_idx[AW-1:0]];
  end

  // advance fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (cmd.exec) begin
      if (mem_we) begin
        fill_count <= fill_count + CW'(1);
      end else if (is_pop && !empty) begin
        fill_count <= fill_count - CW'(1);
      end
    end
  end

  // hold the top entry cache and the result registers
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      top_val   <= rd_data[2*DATA_W-1:DATA_W];
      top_min   <= rd_data[DATA_W-1:0];
      top_value <= rd_data[2*DATA_W-1:DATA_W];
      min_value <= rd_data[DATA_W-1:0];
      is_empty  <= 1'b0;
      status    <= ST_OK;
    end else if (cmd.exec) begin
      if (mem_we) begin
        top_val   <= push_value;
        top_min   <= push_min;
        top_value <= push_value;
        min_value <= push_min;
        is_empty  <= 1'b0;
        status    <= ST_OK;
      end else if (is_pop && (empty || fill_count == CW'(1))) begin
        // pop of the last entry, or refused pop of an empty stack
        top_value <= '0;
        min_value <= INT_MAX;
        is_empty  <= 1'b1;
        status    <= empty ? ST_EMPTY : ST_OK;
      end else if (!is_pop) begin
        // query, unused code, or refused push: report unchanged stack
        top_value <= empty ? '0 : top_val;
        min_value <= empty ? INT_MAX : top_min;
        is_empty  <= empty;
        status    <= is_push ? ST_FULL : ST_OK;
      end
    end
  end

  // fill count never passes the depth
  assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(DEPTH))
    else $error("fill count beyond depth");

endmodule

// File: src/min_tracking_stack.sv
// ----------------------------------------------------------------------------
// min_tracking_stack
// Stack of signed 32-bit values that reports its top and minimum per item.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries opcode and push_value: push,
// pop, or query (code 3 acts as a query). Output channel
// (out_valid/out_ready) returns one result per item: top_value, min_value,
// is_empty and status, all describing the stack after the operation.
// Push, query and refused operations, and a pop that empties the stack,
// show their result in the cycle after acceptance. A pop that leaves
// entries behind passes through a fetch state for the registered read port
// of the entry memory, which supplies the new top and its running minimum.
// Throughput: one item per cycle back to back while results are taken;
// pops that leave entries behind take no new item until their fetch ends.
// A waiting result is held in the output registers; the next item is taken
// in the same cycle that result drains, and nothing is taken while it
// stalls. Reset empties the stack at once; the memory needs no clearing.
// ----------------------------------------------------------------------------
module min_tracking_stack #(
  parameter int DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        opcode,
  input  logic signed [mts_pkg::DATA_W-1:0] push_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mts_pkg::DATA_W-1:0] top_value,
  output logic signed [mts_pkg::DATA_W-1:0] min_value,
  output logic                              is_empty,
  output logic [1:0]                        status
);
  import mts_pkg::*;

  mts_cmd_t cmd;
  mts_sts_t sts;

  // sequence handshakes and pop fetch
  mts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // hold stack storage and results
  mts_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .opcode     (opcode),
    .push_value (push_value),
    .cmd        (cmd),
    .sts        (sts),
    .top_value  (top_value),
    .min_value  (min_value),
    .is_empty   (is_empty),
    .status     (status)
  );

endmodule
